FILE: hdl/multichannel_moving_average_assert.svh
// assertion macros shared by the moving-average rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define MMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mma_pkg.sv
// shared constants, types and tables of the multichannel moving-average filter
// no dependencies
package mma_pkg;

  localparam int CHANNELS    = 16;
  localparam int WINDOW      = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int PERCENT     = 100;

  // field widths fixed by the stream format
  localparam int CHAN_W   = 4;
  localparam int QUAL_W   = 7;
  localparam int ENABLE_W = 16;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW);
  localparam int MEM_AW     = CH_IDX_W + SLOT_W;
  localparam int MEM_DEPTH  = CHANNELS * (2 ** SLOT_W);
  localparam int IN_DATA_W  = ((CHAN_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CHAN_W + SAMPLE_BITS + QUAL_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } mma_state_e;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [FILL_W-1:0] divisor;
  } mma_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } mma_div_rsp_t;

  typedef logic [QUAL_W-1:0] qual_table_t [WINDOW+1];

  function automatic qual_table_t build_quality_table();
    qual_table_t tbl;
    for (int i = 0; i <= WINDOW; i++) begin
      tbl[i] = QUAL_W'((i * PERCENT) / WINDOW);
    end
    return tbl;
  endfunction

  // fill count to percent, rounded down
  localparam qual_table_t QUALITY_LUT = build_quality_table();

endpackage

FILE: hdl/mma_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on mma_pkg
module mma_div import mma_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mma_div_req_t req_i,
  output mma_div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FILL_W-1:0] rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [FILL_W-1:0] divisor_q;

  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;
  logic [FILL_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, divisor_q};
    ge    = trial >= {1'b0, divisor_q};
    rem_d = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: hdl/multichannel_moving_average.sv
// multichannel moving average: a kept beat goes through update, serial divide and output
// states to one result beat (output waits while an untaken result is held); beats are
// taken only in idle, which a dropped beat (channel disabled or out of range) never leaves
// reset clears fill counts, ring pointers, running sums and enables all channels;
// ring contents stay undefined and are used only once written
// depends on mma_pkg, mma_div and multichannel_moving_average_assert.svh
`include "multichannel_moving_average_assert.svh"

module multichannel_moving_average import mma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // channel enable register write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ENABLE_W-1:0]   cfg_data_i,
  // input samples
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // channel[3:0], sample[19:4], zero pad
  // filtered results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // out_channel[3:0], average[19:4],
                                                 // quality[26:20], zero pad
);

  // ---------------------------------------------------------------------------
  // control and per-channel state
  // ---------------------------------------------------------------------------
  mma_state_e state_q, state_d;

  logic [ENABLE_W-1:0] enable_q;

  logic [SLOT_W-1:0]       slot_q [CHANNELS];
  logic [FILL_W-1:0]       fill_q [CHANNELS];
  logic signed [SUM_W-1:0] sum_q  [CHANNELS];

  // ring storage, one row of 2**SLOT_W entries per channel
  logic signed [SAMPLE_BITS-1:0] ring_mem [MEM_DEPTH];
  logic signed [SAMPLE_BITS-1:0] old_q;

  // item in flight
  logic [CHAN_W-1:0]             ch_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          neg_q;
  logic [QUAL_W-1:0]             qual_q;
  logic [SAMPLE_BITS-1:0]        avg_q;

  // output register
  logic                   out_valid_q;
  logic [CHAN_W-1:0]      out_channel_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic [QUAL_W-1:0]      out_qual_q;

  mma_div_req_t div_req;
  mma_div_rsp_t div_rsp;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0]             in_channel;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [CH_IDX_W-1:0]           in_idx;
  logic                          in_range;
  logic                          in_keep;
  logic                          in_accept;
  logic [MEM_AW-1:0]             rd_addr;

  assign in_channel = s_axis_tdata_i[CHAN_W-1:0];
  assign in_sample  = s_axis_tdata_i[CHAN_W +: SAMPLE_BITS];
  assign in_idx     = CH_IDX_W'(in_channel);
  assign in_range   = int'(in_channel) < CHANNELS;
  assign in_keep    = in_range && enable_q[in_channel];
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_addr    = {in_idx, slot_q[in_idx]};

  // ---------------------------------------------------------------------------
  // update of the selected channel
  // ---------------------------------------------------------------------------
  logic [CH_IDX_W-1:0]     ch_idx;
  logic [FILL_W-1:0]       cur_fill;
  logic [FILL_W-1:0]       new_fill;
  logic                    full;
  logic [SLOT_W-1:0]       cur_slot;
  logic [SLOT_W-1:0]       next_slot;
  logic signed [SUM_W-1:0] old_term;
  logic signed [SUM_W-1:0] new_sum;
  logic [SUM_W-1:0]        quo_signed;
  logic                    out_free;

  always_comb begin
    ch_idx    = CH_IDX_W'(ch_q);
    cur_fill  = fill_q[ch_idx];
    full      = cur_fill == FILL_W'(WINDOW);
    new_fill  = full ? cur_fill : cur_fill + 1'b1;
    cur_slot  = slot_q[ch_idx];
    next_slot = (cur_slot == SLOT_W'(WINDOW - 1)) ? '0 : cur_slot + 1'b1;
    // the entry being overwritten leaves the sum only once the ring is full
    old_term  = full ? SUM_W'(old_q) : '0;
    new_sum   = sum_q[ch_idx] - old_term + SUM_W'(sample_q);
    // sign and magnitude division truncates toward zero
    quo_signed = neg_q ? -div_rsp.quotient : div_rsp.quotient;
    out_free   = !out_valid_q || m_axis_tready_i;
  end

  assign div_req.start    = state_q == ST_UPDATE;
  assign div_req.dividend = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
  assign div_req.divisor  = new_fill;

  mma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && in_keep) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // per-channel ring pointer, fill count and running sum
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        slot_q[c] <= '0;
        fill_q[c] <= '0;
        sum_q[c]  <= '0;
      end
    end else if (state_q == ST_UPDATE) begin
      slot_q[ch_idx] <= next_slot;
      fill_q[ch_idx] <= new_fill;
      sum_q[ch_idx]  <= new_sum;
    end
  end

  // ring memory: read the slot about to be overwritten on accept, write it on update
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      ring_mem[{ch_idx, cur_slot}] <= sample_q;
    end
    if (in_accept) begin
      old_q <= ring_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // item payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q     <= in_channel;
      sample_q <= in_sample;
    end
    if (state_q == ST_UPDATE) begin
      neg_q  <= new_sum[SUM_W-1];
      qual_q <= QUALITY_LUT[new_fill];
    end
    if (state_q == ST_DIVIDE && div_rsp.done) begin
      avg_q <= quo_signed[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_OUTPUT && out_free) begin
      out_channel_q <= ch_q;
      out_avg_q     <= avg_q;
      out_qual_q    <= qual_q;
    end
  end

  // output beat valid: loaded from the output state, dropped when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUTPUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_qual_q, out_avg_q, out_channel_q});

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `MMA_ASSERT_NEXT(a_kept_beat_updates, in_accept && in_keep, state_q == ST_UPDATE, "kept beat did not start an update")
  `MMA_ASSERT_NOW(a_done_in_divide, div_rsp.done, state_q == ST_DIVIDE, "divider finished outside divide state")
  `MMA_ASSERT_NOW(a_fill_bounded, state_q == ST_UPDATE, cur_fill <= FILL_W'(WINDOW), "fill count beyond window")
  `MMA_ASSERT_NEXT(a_result_loaded, state_q == ST_OUTPUT && out_free, m_axis_tvalid_o && state_q == ST_IDLE, "result not loaded into output register")

endmodule

FILE: test/multichannel_moving_average_test.sv
// self-checking testbench for the multichannel moving-average filter
// holds its own per-channel window predictor and a result scoreboard
// depends on mma_pkg and the multichannel_moving_average rtl
module multichannel_moving_average_test import mma_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ENABLE_W-1:0] ALL_CHANNELS_ON  = '1;
  localparam logic [ENABLE_W-1:0] ALL_CHANNELS_OFF = '0;
  localparam int SETTLE_CYCLES  = 40;    // a margin over the input-to-result latency
  localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
  localparam int HOLD_AT_RESULT = 150;   // hold-off starts after this many results
  localparam int IDLE_PERCENT   = 33;
  // no beat on any channel for this long means the block is stuck; the longest
  // legal silence is the receiver hold-off plus the processing of one sample
  localparam int STUCK_LIMIT    = 4000;
  localparam int PHASE_TARGET   = 150;   // kept samples per random enable setting
  localparam int SAMPLE_MAX     = 32767;
  localparam int SAMPLE_MIN     = -32768;

  // one filtered value as it leaves the block
  typedef struct {
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [QUAL_W-1:0]             quality;
  } filtered_t;

  // per-channel window predictor plus the queue of averages still owed
  class moving_average_scoreboard;
    int ring [CHANNELS][WINDOW];
    int next_slot [CHANNELS];
    int fill [CHANNELS];
    int running_sum [CHANNELS];
    logic [ENABLE_W-1:0] enable_mask;
    filtered_t pending_averages [$];
    int mismatches;
    int kept;
    int dropped;
    int checked;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        next_slot[c]   = 0;
        fill[c]        = 0;
        running_sum[c] = 0;
      end
      enable_mask = ALL_CHANNELS_ON;
      mismatches  = 0;
      kept        = 0;
      dropped     = 0;
      checked     = 0;
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // an input beat was taken: update the window and queue the average it owes
    function void note_sample(input logic [CHAN_W-1:0] chan,
                              input logic signed [SAMPLE_BITS-1:0] sample);
      filtered_t res;
      int c;
      c = chan;
      if (c >= CHANNELS || !enable_mask[c]) begin
        dropped++;
        return;
      end
      // a full ring gives up its oldest entry before the new one lands
      if (fill[c] >= WINDOW) running_sum[c] -= ring[c][next_slot[c]];
      ring[c][next_slot[c]] = sample;
      running_sum[c] += sample;
      next_slot[c] = (next_slot[c] + 1) % WINDOW;
      if (fill[c] < WINDOW) fill[c]++;
      res.chan    = chan;
      res.average = SAMPLE_BITS'(running_sum[c] / fill[c]);  // truncates toward zero
      res.quality = QUAL_W'((fill[c] * PERCENT) / WINDOW);
      pending_averages.push_back(res);
      kept++;
    endfunction

    task check_result(input logic [OUT_DATA_W-1:0] data);
      filtered_t exp_res;
      logic [CHAN_W-1:0]             got_chan;
      logic signed [SAMPLE_BITS-1:0] got_avg;
      logic [QUAL_W-1:0]             got_qual;
      got_chan = data[CHAN_W-1:0];
      got_avg  = data[CHAN_W +: SAMPLE_BITS];
      got_qual = data[CHAN_W+SAMPLE_BITS +: QUAL_W];
      checked++;
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", data));
        return;
      end
      exp_res = pending_averages.pop_front();
      if (got_chan !== exp_res.chan)
        report_mismatch($sformatf("channel %0d, want %0d", got_chan, exp_res.chan));
      if (got_avg !== exp_res.average)
        report_mismatch($sformatf("ch %0d average %0d, want %0d",
                                  exp_res.chan, got_avg, exp_res.average));
      if (got_qual !== exp_res.quality)
        report_mismatch($sformatf("ch %0d quality %0d, want %0d",
                                  exp_res.chan, got_qual, exp_res.quality));
      if (data[OUT_DATA_W-1:CHAN_W+SAMPLE_BITS+QUAL_W] !== '0)
        report_mismatch($sformatf("nonzero pad bits in %h", data));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [ENABLE_W-1:0]   cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // channel[3:0], sample[19:4], zero pad
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // out_channel[3:0], average[19:4],
                                                 // quality[26:20], zero pad

  moving_average_scoreboard sb = new();

  // set during one random phase: neither side idles at random then
  bit steady = 1'b0;
  bit hold_done = 1'b0;
  int settings_used = 0;

  multichannel_moving_average u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // offer one sample beat, with a random gap first, and wait until it is taken
  task automatic send_sample(input logic [CHAN_W-1:0] chan,
                             input logic signed [SAMPLE_BITS-1:0] sample);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({sample, chan});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_sample(chan, sample);
  endtask

  // stop offering and wait until every owed average is back and the divider is quiet
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_enable(input logic [ENABLE_W-1:0] mask);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mask;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.enable_mask = mask;
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // extremes often, tiny values near zero for rounding, otherwise anything
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_BITS'(SAMPLE_MAX);
      1:       return SAMPLE_BITS'(SAMPLE_MIN);
      2:       return SAMPLE_BITS'(int'($urandom_range(8)) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly enabled channels so the windows fill and wrap; some dropped noise
  function automatic logic [CHAN_W-1:0] pick_channel(input logic [ENABLE_W-1:0] mask);
    logic [CHAN_W-1:0] chan;
    chan = CHAN_W'($urandom);
    if (mask != ALL_CHANNELS_OFF && $urandom_range(99) < 85) begin
      while (!mask[chan]) chan = CHAN_W'($urandom);
    end
    return chan;
  endfunction

  // result side: random stalls, none while steady, and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (!hold_done && sb.checked >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // watchdog: any beat on any channel restarts the count
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STUCK_LIMIT) begin
        $display("[%0t] no beat for %0d cycles", $realtime, STUCK_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [ENABLE_W-1:0] settings [8];
    logic [ENABLE_W-1:0] mask;
    int phase_kept;
    int phase_sent;
    int sent_cap;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: positive full scale fills channel 0 past one wrap
    for (int i = 0; i <= WINDOW; i++) send_sample(4'd0, SAMPLE_BITS'(SAMPLE_MAX));
    // negative full scale on the top channel, most negative running sum
    for (int i = 0; i <= WINDOW; i++) send_sample(4'd15, SAMPLE_BITS'(SAMPLE_MIN));
    // small negatives check truncation toward zero
    send_sample(4'd5, -16'sd1);
    send_sample(4'd5, 16'sd2);
    send_sample(4'd5, -16'sd7);
    drain();
    // disabled channel is dropped and leaves its window alone
    write_enable(16'hFFFE);
    send_sample(4'd0, 16'sd1234);
    send_sample(4'd1, SAMPLE_BITS'(SAMPLE_MAX));
    drain();
    write_enable(ALL_CHANNELS_OFF);
    send_sample(4'd15, SAMPLE_BITS'(SAMPLE_MIN));
    drain();

    // random phases, one enable setting each; the block is idle between them
    settings[0] = ALL_CHANNELS_ON;
    settings[1] = ENABLE_W'($urandom);
    settings[2] = 16'h0001;
    settings[3] = 16'h8000;
    settings[4] = 16'hA5A5;
    settings[5] = ALL_CHANNELS_OFF;
    settings[6] = ENABLE_W'($urandom);
    settings[7] = ALL_CHANNELS_ON;
    for (int p = 0; p < 8; p++) begin
      mask = settings[p];
      write_enable(mask);
      steady     = (p == 0);
      phase_kept = 0;
      phase_sent = 0;
      sent_cap   = (mask == ALL_CHANNELS_OFF) ? 30 : PHASE_TARGET * 4;
      while (phase_kept < PHASE_TARGET && phase_sent < sent_cap) begin
        logic [CHAN_W-1:0] chan;
        chan = pick_channel(mask);
        if (mask[chan]) phase_kept++;
        phase_sent++;
        send_sample(chan, pick_sample());
      end
      steady = 1'b0;
      // the sender holds off here until every owed result is back
      drain();
    end

    $display("run covered %0d kept samples and %0d dropped beats over %0d enable settings",
             sb.kept, sb.dropped, settings_used);
    $display("%0d results checked, including one %0d-cycle receiver hold-off",
             sb.checked, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending_averages.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
